>>> rtl/incremental_reachability_cycle_count_top_assert.svh
// Assertion macros shared by the reachability block's RTL modules.
// No dependencies; included by the controller and datapath files.
`ifndef INCREMENTAL_REACHABILITY_CYCLE_COUNT_TOP_ASSERT_SVH
`define INCREMENTAL_REACHABILITY_CYCLE_COUNT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define IRCC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define IRCC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ircc_pkg.sv
// Shared types and constants of the reachability / cycle-count block.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package ircc_pkg;

    localparam int ID_W         = 8;
    localparam int NODE_COUNT_W = 9;
    localparam int COUNT_OUT_W  = 16;
    localparam int S_TDATA_W    = 2 * ID_W;
    localparam int M_TDATA_W    = 24;

    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 9'd256;

    // request kinds carried on s_tuser
    localparam logic REQ_CLEAR = 1'b0;
    localparam logic REQ_EDGE  = 1'b1;

    typedef struct packed {
        logic load;         // capture input request
        logic idx_reset;    // restart row index
        logic clr_step;     // write identity row at index, advance
        logic rd_to;        // read destination row
        logic latch_to;     // hold destination row
        logic sweep_rd;     // read row at index, advance
        logic count_clear;
        logic count_inc;
        logic publish;      // load output register
        logic pub_cyc;
        logic pub_bad;
    } cmd_t;

    typedef struct packed {
        logic req_edge;
        logic bad;
        logic cyc_hit;
        logic idx_last;
        logic out_busy;
    } status_t;

endpackage

>>> rtl/ircc_ctrl.sv
// Sequencer of the reachability block: boot clear, decode, row sweep, output.
// Depends on ircc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "incremental_reachability_cycle_count_top_assert.svh"

module ircc_ctrl
    import ircc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output cmd_t    cmd,
    input  status_t status
);

    typedef enum logic [3:0] {
        ST_CLR_BOOT,
        ST_IDLE,
        ST_DECODE,
        ST_CLR_REQ,
        ST_WAIT_TO,
        ST_CHECK,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   res_cyc_reg, res_cyc_next;
    logic   res_bad_reg, res_bad_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        res_cyc_next = res_cyc_reg;
        res_bad_next = res_bad_reg;
        cmd          = '0;
        cmd.pub_cyc  = res_cyc_reg;
        cmd.pub_bad  = res_bad_reg;
        unique case (state_reg)
            ST_CLR_BOOT: begin
                cmd.clr_step = 1'b1;
                if (status.idx_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                res_cyc_next = 1'b0;
                res_bad_next = 1'b0;
                if (!status.req_edge) begin
                    cmd.count_clear = 1'b1;
                    cmd.idx_reset   = 1'b1;
                    state_next      = ST_CLR_REQ;
                end else if (status.bad) begin
                    res_bad_next = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    cmd.rd_to  = 1'b1;
                    state_next = ST_WAIT_TO;
                end
            end
            ST_CLR_REQ: begin
                cmd.clr_step = 1'b1;
                if (status.idx_last) state_next = ST_DONE;
            end
            ST_WAIT_TO: begin
                cmd.latch_to = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK: begin
                // destination already reaches source: count, leave matrix alone
                if (status.cyc_hit) begin
                    cmd.count_inc = 1'b1;
                    res_cyc_next  = 1'b1;
                    state_next    = ST_DONE;
                end else begin
                    cmd.idx_reset = 1'b1;
                    state_next    = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                cmd.sweep_rd = 1'b1;
                if (status.idx_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                // last row write-back lands this cycle
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR_BOOT;
            res_cyc_reg <= 1'b0;
            res_bad_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            res_cyc_reg <= res_cyc_next;
            res_bad_reg <= res_bad_next;
        end
    end

    `IRCC_ASSERT_NOW(a_publish_free, aclk, aresetn, cmd.publish, !status.out_busy, "result published over a pending result")
    `IRCC_ASSERT_NEXT(a_accept_decode, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_DECODE, "accepted request not decoded next")
    `IRCC_ASSERT_NOW(a_no_cycle_and_bad, aclk, aresetn, cmd.publish, !(cmd.pub_cyc && cmd.pub_bad), "cycle and bad flags both set")

endmodule

>>> rtl/ircc_datapath.sv
// Datapath of the reachability block: matrix memory, row sweep, counter,
// node limit check, output register. Depends on ircc_pkg and the macro header.
`timescale 1ns / 1ps
`include "incremental_reachability_cycle_count_top_assert.svh"

module ircc_datapath
    import ircc_pkg::*;
#(
    parameter int MAX_NODES  = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [S_TDATA_W-1:0]    s_tdata,
    input  logic                    s_tuser,
    input  logic                    cfg_valid,
    input  logic [NODE_COUNT_W-1:0] cfg_data,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata,
    input  cmd_t                    cmd,
    output status_t                 status
);

    localparam int ADDR_W = $clog2(MAX_NODES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef logic [MAX_NODES-1:0] row_t;

    row_t reach_mem [MAX_NODES];

    logic                    req_reg;
    logic [ID_W-1:0]         from_reg;
    logic [ID_W-1:0]         to_reg;
    logic [NODE_COUNT_W-1:0] node_count_reg;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]       idx_reg;
    logic [ADDR_W-1:0]       wr_idx_reg;
    logic                    sweep_vld_reg;
    row_t                    rd_data_reg;
    row_t                    to_row_reg;
    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    logic              idx_last;
    logic [ADDR_W-1:0] from_col;
    logic [ADDR_W-1:0] to_col;
    logic              from_bad;
    logic              to_bad;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    row_t              mem_wdata;

    assign from_col = ADDR_W'(from_reg);
    assign to_col   = ADDR_W'(to_reg);
    assign idx_last = (idx_reg == ADDR_W'(MAX_NODES - 1));

    // limit is node_count capped at MAX_NODES
    assign from_bad = ({1'b0, from_reg} >= node_count_reg) || (int'(from_reg) >= MAX_NODES);
    assign to_bad   = ({1'b0, to_reg} >= node_count_reg) || (int'(to_reg) >= MAX_NODES);

    assign status.req_edge = (req_reg == REQ_EDGE);
    assign status.bad      = from_bad || to_bad;
    assign status.cyc_hit  = to_row_reg[from_col];
    assign status.idx_last = idx_last;
    assign status.out_busy = m_tvalid_reg && !m_tready;

    // sweep writes back a row in the cycle after reading it, only if it reached "from"
    assign mem_we    = cmd.clr_step || (sweep_vld_reg && rd_data_reg[from_col]);
    assign mem_waddr = cmd.clr_step ? idx_reg : wr_idx_reg;
    assign mem_wdata = cmd.clr_step ? (row_t'(1) << idx_reg) : (rd_data_reg | to_row_reg);
    assign mem_re    = cmd.rd_to || cmd.sweep_rd;
    assign mem_raddr = cmd.rd_to ? to_col : idx_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) reach_mem[mem_waddr] <= mem_wdata;
        if (mem_re) rd_data_reg <= reach_mem[mem_raddr];
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.count_clear) begin
            count_next = '0;
        end else if (cmd.count_inc && (count_reg != COUNT_MAX)) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NODE_COUNT_RESET;
            count_reg      <= '0;
            idx_reg        <= '0;
            sweep_vld_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) node_count_reg <= cfg_data;
            count_reg     <= count_next;
            sweep_vld_reg <= cmd.sweep_rd;
            if (cmd.idx_reset) begin
                idx_reg <= '0;
            end else if (cmd.clr_step || cmd.sweep_rd) begin
                idx_reg <= idx_last ? '0 : idx_reg + 1'b1;
            end
            if (cmd.publish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= s_tuser;
            from_reg <= s_tdata[ID_W-1:0];
            to_reg   <= s_tdata[2*ID_W-1:ID_W];
        end
        if (cmd.sweep_rd) wr_idx_reg <= idx_reg;
        if (cmd.latch_to) to_row_reg <= rd_data_reg;
        if (cmd.publish) begin
            m_tdata_reg <= {{(M_TDATA_W - COUNT_OUT_W - 2){1'b0}}, cmd.pub_bad,
                            COUNT_OUT_W'(count_reg), cmd.pub_cyc};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `IRCC_ASSERT_NOW(a_port_collision, aclk, aresetn, mem_we && mem_re, mem_waddr != mem_raddr, "matrix read and write hit the same row")
    `IRCC_ASSERT_NEXT(a_count_saturates, aclk, aresetn, cmd.count_inc && (count_reg == COUNT_MAX), count_reg == COUNT_MAX, "cycle counter wrapped")
    `IRCC_ASSERT_NOW(a_sweep_exclusive, aclk, aresetn, cmd.sweep_rd, !cmd.clr_step && !cmd.rd_to, "sweep read overlaps another matrix access")

endmodule

>>> rtl/incremental_reachability_cycle_count_top.sv
// Reachability matrix with cycle counting: each request clears the graph or
// adds one directed edge; every request returns one result.
// s_tuser: req_type (0 clear, 1 edge). s_tdata: from_node, to_node.
// m_tdata: closes_cycle, cycle_count, bad_node. cfg_data: node_count.
// m_tvalid rises in the same cycle that s_tready returns for the next
// request. The matrix memory has one read and one write port, so the
// update sweep visits one row per cycle and sets the long latencies; one
// request is in flight at a time, and a new one is accepted while the
// last result still waits on m_tready. A stalled receiver holds the
// result and, once the next request is done, holds the block in its
// final state. Reset (aresetn low, synchronous) clears the counter, sets
// node_count to 256, then runs a pass over all MAX_NODES rows that writes
// the identity rows; s_tready stays low during that pass. cfg_ready is
// always high; write node_count only while idle. Depends on ircc_pkg,
// ircc_ctrl, ircc_datapath.
`timescale 1ns / 1ps

module incremental_reachability_cycle_count_top
    import ircc_pkg::*;
#(
    parameter int MAX_NODES  = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,   // [7:0] from_node, [15:8] to_node
    input  logic                    s_tuser,   // [0] req_type
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata,   // [0] closes_cycle, [16:1] cycle_count,
                                               // [17] bad_node, [23:18] zero
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [NODE_COUNT_W-1:0] cfg_data   // node_count
);

    cmd_t    cmd;
    status_t status;
    logic    cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    ircc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    ircc_datapath #(
        .MAX_NODES  (MAX_NODES),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_write),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> verif/ircc_reach_checker.sv
// Scoreboard for the reachability / cycle-count block: mirrors the reach matrix and counter,
// predicts one result per accepted request and compares it with the result stream.
// Depends on ircc_pkg; instantiated beside the block by tb_incremental_reachability_cycle_count_top.
`timescale 1ns / 1ps

module ircc_reach_checker
    import ircc_pkg::*;
#(
    parameter int MAX_NODES  = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,   // [7:0] from_node, [15:8] to_node
    input  logic                    s_tuser,   // [0] req_type
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [M_TDATA_W-1:0]    m_tdata,   // [0] closes_cycle, [16:1] cycle_count,
                                               // [17] bad_node
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [NODE_COUNT_W-1:0] cfg_data,  // node_count
    output int                      mismatch_count,
    output int                      pending_results
);

    typedef struct packed {
        logic                   closes_cycle;
        logic [COUNT_OUT_W-1:0] cycle_count;
        logic                   bad_node;
    } edge_result_t;

    logic [MAX_NODES-1:0]    reach [MAX_NODES];
    logic [COUNT_BITS-1:0]   cycle_total;
    logic [NODE_COUNT_W-1:0] node_count_q;
    edge_result_t            expected_results [$];
    int                      mismatches = 0;

    assign mismatch_count = mismatches;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic restore_identity();
        int r;
        for (r = 0; r < MAX_NODES; r++) begin
            reach[r]    = '0;
            reach[r][r] = 1'b1;
        end
    endtask

    // Update the mirrored graph for one request and return what the block must answer.
    task automatic apply_request(input logic kind, input logic [ID_W-1:0] src,
                                 input logic [ID_W-1:0] dst, output edge_result_t res);
        int                   limit;
        int                   r;
        logic [MAX_NODES-1:0] dst_row;
        res   = '0;
        limit = (node_count_q < MAX_NODES) ? int'(node_count_q) : MAX_NODES;
        if (kind == REQ_CLEAR) begin
            restore_identity();
            cycle_total = '0;
        end else if (int'(src) >= limit || int'(dst) >= limit) begin
            res.bad_node = 1'b1;
        end else if (reach[dst][src]) begin
            res.closes_cycle = 1'b1;
            if (cycle_total != '1)
                cycle_total = cycle_total + 1'b1;
        end else begin
            // every node that reaches src now also reaches whatever dst reaches
            dst_row = reach[dst];
            for (r = 0; r < MAX_NODES; r++) begin
                if (reach[r][src])
                    reach[r] = reach[r] | dst_row;
            end
        end
        res.cycle_count = COUNT_OUT_W'(cycle_total);
    endtask

    always @(posedge aclk) begin : watch_channels
        edge_result_t seen;
        edge_result_t want;
        if (!aresetn) begin
            restore_identity();
            cycle_total  = '0;
            node_count_q = NODE_COUNT_RESET;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                node_count_q = cfg_data;
            if (m_tvalid && m_tready) begin
                seen.closes_cycle = m_tdata[0];
                seen.cycle_count  = m_tdata[16:1];
                seen.bad_node     = m_tdata[17];
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with no request pending: tdata %h",
                                              m_tdata));
                end else begin
                    want = expected_results.pop_front();
                    if (seen.closes_cycle !== want.closes_cycle)
                        report_mismatch($sformatf("closes_cycle got %b expected %b",
                                                  seen.closes_cycle, want.closes_cycle));
                    if (seen.cycle_count !== want.cycle_count)
                        report_mismatch($sformatf("cycle_count got %0d expected %0d",
                                                  seen.cycle_count, want.cycle_count));
                    if (seen.bad_node !== want.bad_node)
                        report_mismatch($sformatf("bad_node got %b expected %b",
                                                  seen.bad_node, want.bad_node));
                end
            end
            if (s_tvalid && s_tready) begin
                apply_request(s_tuser, s_tdata[ID_W-1:0], s_tdata[2*ID_W-1:ID_W], want);
                expected_results.insert(expected_results.size(), want);
            end
        end
        pending_results <= expected_results.size();
    end

endmodule

>>> verif/tb_incremental_reachability_cycle_count_top.sv
// Top of the reachability / cycle-count testbench: clock, reset, request and node_count
// stimulus with random idling, and the verdict. Depends on ircc_pkg, the block and ircc_reach_checker.
`timescale 1ns / 1ps

module tb_incremental_reachability_cycle_count_top;
    import ircc_pkg::*;

    localparam int MAX_NODES     = 256;
    localparam int COUNT_BITS    = 16;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 153;
    localparam int SETTLE_CYCLES = 16;
    localparam int END_WAIT      = 2 * MAX_NODES;
    localparam int CYCLE_LIMIT   = 3_000_000;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;   // [7:0] from_node, [15:8] to_node
    logic                    s_tuser;   // [0] req_type
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;   // [0] closes_cycle, [16:1] cycle_count, [17] bad_node
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [NODE_COUNT_W-1:0] cfg_data;  // node_count

    int mismatch_count;
    int pending_results;
    int cycle_cnt    = 0;
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    bit quiet        = 1'b0;

    // node_count, id window and idling per random phase
    int phase_nodes  [PHASES] = '{256, 2, 16, 5, 100, 1, 256, 9, 40, 256};
    int phase_window [PHASES] = '{256, 2, 8, 5, 10, 1, 20, 9, 12, 256};
    int phase_tx_gap [PHASES] = '{20, 0, 40, 10, 0, 30, 5, 50, 15, 0};
    int phase_rx     [PHASES] = '{2, 0, 5, 1, 10, 0, 3, 1, 0, 0};

    incremental_reachability_cycle_count_top #(
        .MAX_NODES (MAX_NODES),
        .COUNT_BITS(COUNT_BITS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    ircc_reach_checker #(
        .MAX_NODES (MAX_NODES),
        .COUNT_BITS(COUNT_BITS)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_results(pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stall bursts, none once the run goes quiet
    initial begin
        forever begin
            if (!quiet && $urandom_range(0, 99) < rx_stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Hold the request until accepted; valid stays up for a back-to-back request.
    task automatic send_request(input logic kind, input logic [ID_W-1:0] src,
                                input logic [ID_W-1:0] dst);
        if (!quiet && $urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {dst, src};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_node_count(input logic [NODE_COUNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int   p;
        int   limit;
        int   window;
        int   base;
        int   roll;
        int   src;
        int   dst;
        logic kind;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_CLEAR;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: node_count at its reset value of 256
        send_request(REQ_CLEAR, 8'h5A, 8'hA5);
        send_request(REQ_EDGE, 8'd0, 8'd1);
        send_request(REQ_EDGE, 8'd1, 8'd2);
        send_request(REQ_EDGE, 8'd2, 8'd0);
        send_request(REQ_EDGE, 8'd255, 8'd254);
        send_request(REQ_EDGE, 8'd254, 8'd255);
        send_request(REQ_EDGE, 8'd255, 8'd255);
        send_request(REQ_EDGE, 8'd0, 8'd255);
        send_request(REQ_EDGE, 8'd170, 8'd85);
        send_request(REQ_EDGE, 8'd85, 8'd170);

        // shrink the node range without a clear: the matrix is kept
        drain_results();
        write_node_count(9'd3);
        send_request(REQ_EDGE, 8'd0, 8'd2);
        send_request(REQ_EDGE, 8'd2, 8'd3);
        send_request(REQ_EDGE, 8'd4, 8'd0);
        send_request(REQ_EDGE, 8'd1, 8'd0);
        send_request(REQ_EDGE, 8'd255, 8'd0);

        drain_results();
        write_node_count(9'd1);
        send_request(REQ_EDGE, 8'd0, 8'd0);
        send_request(REQ_EDGE, 8'd0, 8'd1);
        send_request(REQ_CLEAR, 8'd0, 8'd0);
        send_request(REQ_EDGE, 8'd0, 8'd0);

        // zero nodes: every id is out of range
        drain_results();
        write_node_count(9'd0);
        send_request(REQ_EDGE, 8'd0, 8'd0);
        send_request(REQ_CLEAR, 8'hFF, 8'hFF);

        for (p = 0; p < PHASES; p++) begin
            drain_results();
            write_node_count(NODE_COUNT_W'(phase_nodes[p]));
            limit        = (phase_nodes[p] < MAX_NODES) ? phase_nodes[p] : MAX_NODES;
            window       = phase_window[p];
            tx_gap_pct   = phase_tx_gap[p];
            rx_stall_pct = phase_rx[p];
            quiet        = (p == PHASES - 1);
            base         = $urandom_range(0, limit - window);
            repeat (PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                kind = REQ_EDGE;
                if (roll < 4) begin
                    kind = REQ_CLEAR;
                    src  = $urandom_range(0, 255);
                    dst  = $urandom_range(0, 255);
                    base = $urandom_range(0, limit - window);
                end else if (roll < 10 && limit < 256) begin
                    src = $urandom_range(0, limit - 1);
                    dst = $urandom_range(0, limit - 1);
                    case ($urandom_range(0, 2))
                        0: src = $urandom_range(limit, 255);
                        1: dst = $urandom_range(limit, 255);
                        default: begin
                            src = $urandom_range(limit, 255);
                            dst = $urandom_range(limit, 255);
                        end
                    endcase
                end else begin
                    // edges inside a narrow window so that cycles show up often
                    src = base + $urandom_range(0, window - 1);
                    dst = base + $urandom_range(0, window - 1);
                end
                if (roll == 99)
                    drain_results();
                send_request(kind, ID_W'(src), ID_W'(dst));
            end
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (END_WAIT) @(posedge aclk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
